/* hdl/ccbd_pkg.sv */
// ---------------------------------------------------------------------------
// ccbd_pkg: shared types and constants of the centre-crop box downscaler
// Thumbnail geometry, field widths, register indexes and queue sizing.
// ---------------------------------------------------------------------------
package ccbd_pkg;

  localparam int OUT_W   = 64;
  localparam int OUT_H   = 32;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 5;
  localparam int CH_W    = 8;
  localparam int CFG_DW  = 13;
  localparam int CFG_IW  = 2;
  localparam int Q_DEPTH = 4;
  localparam int Q_PW    = 2;
  localparam int Q_CW    = 3;
  // restoring divide, one quotient bit per cycle
  localparam int QB      = 8;

  localparam logic [CFG_IW-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SRC_HEIGHT = 2'd1;

  localparam logic [CFG_DW-1:0] RST_SRC_WIDTH  = 13'd64;
  localparam logic [CFG_DW-1:0] RST_SRC_HEIGHT = 13'd32;

  localparam logic [COL_W-1:0] LAST_COL = 6'd63;
  localparam logic [ROW_W-1:0] LAST_ROW = 5'd31;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pos_t;

endpackage

/* hdl/ccbd_ifs.sv */
// ---------------------------------------------------------------------------
// ccbd channel interfaces
// Pixel input, thumbnail result and configuration write channels.
// ---------------------------------------------------------------------------
interface ccbd_pix_if;
  import ccbd_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ccbd_res_if;
  import ccbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;
  logic             frame_last;
  modport source (output valid, out_red, out_green, out_blue, out_column, out_row,
                  frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_column, out_row,
                  frame_last, output ready);
endinterface

interface ccbd_cfg_if;
  import ccbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/ccbd_ram.sv */
// ---------------------------------------------------------------------------
// ccbd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ccbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ccbd_front.sv */
// ---------------------------------------------------------------------------
// ccbd_front: pixel front end
// Holds the source size, derives the crop window, tracks the raster position
// and block counters, and accumulates block sums in the column store. A
// finished block is pushed to the queue.
// ---------------------------------------------------------------------------
module ccbd_front #(
  parameter int MAX_SOURCE_DIM = 4096,
  parameter int DIM_W          = 13,
  parameter int BLK_W          = 8,
  parameter int SUM_W          = 24,
  parameter int DIV_W          = 16,
  parameter int ENT_W          = 84
) (
  input  logic             clk,
  input  logic             rst_n,
  ccbd_cfg_if.sink         cfg,
  ccbd_pix_if.sink         pix,
  output logic             q_push,
  output logic [ENT_W-1:0] q_data,
  input  logic             q_full,
  input  logic             q_afull,
  output logic [DIV_W-1:0] div
);
  import ccbd_pkg::*;

  localparam int CW = (DIM_W > CFG_DW) ? DIM_W : CFG_DW;
  localparam logic [CW-1:0] MAXV = CW'(MAX_SOURCE_DIM);

  // configuration registers
  logic [CFG_DW-1:0] src_w_r, src_h_r;
  logic              cfg_fire, restart;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;
  assign restart   = cfg_fire && (cfg.index == REG_SRC_WIDTH || cfg.index == REG_SRC_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SRC_WIDTH;
      src_h_r <= RST_SRC_HEIGHT;
    end else if (cfg_fire) begin
      if (cfg.index == REG_SRC_WIDTH) src_w_r <= cfg.data;
      if (cfg.index == REG_SRC_HEIGHT) src_h_r <= cfg.data;
    end
  end

  // crop geometry, registered from the configuration registers
  logic [DIM_W-1:0] w, h, offx, offy, wm1_r, hm1_r, offx_r, offy_r;
  logic [DIM_W:0]   xend, yend, xend_r, yend_r, wdiff;
  logic [BLK_W-1:0] blk, blk_r, bm1_r;
  logic [DIV_W-1:0] div_r;
  logic             wide, act_r, bnz_r, geo_ok_r;

  always_comb begin
    w     = (CW'(src_w_r) > MAXV) ? DIM_W'(MAXV) : DIM_W'(src_w_r);
    h     = (CW'(src_h_r) > MAXV) ? DIM_W'(MAXV) : DIM_W'(src_h_r);
    wide  = {1'b0, w} > {h, 1'b0};
    wdiff = {1'b0, w} - {h, 1'b0};
    if (wide) begin
      blk  = h[DIM_W-1:5];
      offx = wdiff[DIM_W:1];
      offy = '0;
    end else begin
      blk  = BLK_W'(w[DIM_W-1:6]);
      offx = '0;
      offy = DIM_W'((h - {1'b0, w[DIM_W-1:1]}) >> 1);
    end
    xend = {1'b0, offx} + ((DIM_W+1)'(blk) << 6);
    yend = {1'b0, offy} + ((DIM_W+1)'(blk) << 5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_ok_r <= 1'b0;
    end else begin
      geo_ok_r <= !cfg_fire;
    end
    wm1_r  <= w - 1'b1;
    hm1_r  <= h - 1'b1;
    act_r  <= (w != '0) && (h != '0);
    bnz_r  <= blk != '0;
    blk_r  <= blk;
    bm1_r  <= blk - 1'b1;
    offx_r <= offx;
    offy_r <= offy;
    xend_r <= xend;
    yend_r <= yend;
    div_r  <= DIV_W'(blk) * DIV_W'(blk);
  end

  assign div = div_r;

  // raster position and block counters
  logic [DIM_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [BLK_W-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             fire, hit, s1_emit_pend;

  assign fire = pix.valid && pix.ready;
  assign hit  = act_r && bnz_r && (x_r >= offx_r) && ({1'b0, x_r} < xend_r)
             && (y_r >= offy_r) && ({1'b0, y_r} < yend_r);

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; cx_nxt = cx_r; cy_nxt = cy_r;
    col_nxt = col_r; row_nxt = row_r;
    if (restart) begin
      x_nxt = '0; y_nxt = '0; cx_nxt = '0; cy_nxt = '0; col_nxt = '0; row_nxt = '0;
    end else if (fire && act_r) begin
      if (x_r == wm1_r) begin
        x_nxt = '0; cx_nxt = '0; col_nxt = '0;
        if (y_r == hm1_r) begin
          y_nxt = '0; cy_nxt = '0; row_nxt = '0;
        end else begin
          y_nxt = y_r + 1'b1;
          if (y_r >= offy_r) begin
            if (cy_r == bm1_r) begin
              cy_nxt  = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              cy_nxt = cy_r + 1'b1;
            end
          end
        end
      end else begin
        x_nxt = x_r + 1'b1;
        if (x_r >= offx_r) begin
          if (cx_r == bm1_r) begin
            cx_nxt  = '0;
            col_nxt = col_r + 1'b1;
          end else begin
            cx_nxt = cx_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0; y_r <= '0; cx_r <= '0; cy_r <= '0; col_r <= '0; row_r <= '0;
    end else begin
      x_r <= x_nxt; y_r <= y_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
      col_r <= col_nxt; row_r <= row_nxt;
    end
  end

  // accumulate stage: read at accept, add and write back next cycle
  logic                s1_v_r, s1_first_r;
  pos_t                s1_pos_r;
  logic [3*CH_W-1:0]   s1_pix_r;
  logic [3*SUM_W-1:0]  rdata, base, sums, fwd_data_r;
  logic [COL_W-1:0]    fwd_addr_r;
  logic                fwd_v_r;

  assign s1_emit_pend = s1_v_r && s1_pos_r.last;
  assign pix.ready    = geo_ok_r && !q_full && !(q_afull && s1_emit_pend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r <= fire && hit;
      if (s1_v_r) fwd_v_r <= 1'b1;
    end
    if (fire && hit) begin
      s1_first_r    <= (cx_r == '0) && (cy_r == '0);
      s1_pos_r.col  <= col_r;
      s1_pos_r.row  <= row_r;
      s1_pos_r.last <= (cx_r == bm1_r) && (cy_r == bm1_r);
      s1_pix_r      <= {pix.blue, pix.green, pix.red};
    end
    if (s1_v_r) begin
      fwd_addr_r <= s1_pos_r.col;
      fwd_data_r <= sums;
    end
  end

  ccbd_ram #(.WIDTH(3*SUM_W), .DEPTH(OUT_W)) u_sums (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_pos_r.col),
    .wdata (sums),
    .re    (fire && hit),
    .raddr (col_r),
    .rdata (rdata)
  );

  // a block's top-left pixel starts a fresh sum
  always_comb begin
    if (s1_first_r) begin
      base = '0;
    end else if (fwd_v_r && fwd_addr_r == s1_pos_r.col) begin
      base = fwd_data_r;
    end else begin
      base = rdata;
    end
    for (int c = 0; c < 3; c++) begin
      sums[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] + SUM_W'(s1_pix_r[c*CH_W +: CH_W]);
    end
  end

  assign q_push = s1_emit_pend;
  assign q_data = {sums, s1_pos_r.col, s1_pos_r.row,
                   (s1_pos_r.col == LAST_COL) && (s1_pos_r.row == LAST_ROW)};

endmodule

/* hdl/ccbd_fifo.sv */
// ---------------------------------------------------------------------------
// ccbd_fifo: finished-block queue
// Short register queue between the front end and the divider.
// ---------------------------------------------------------------------------
module ccbd_fifo #(
  parameter int WIDTH = 84
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full,
  output logic             afull
);
  import ccbd_pkg::*;

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [Q_PW-1:0]  wp_r, rp_r;
  logic [Q_CW-1:0]  cnt_r;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == Q_CW'(Q_DEPTH);
  assign afull = cnt_r >= Q_CW'(Q_DEPTH - 1);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + Q_CW'(push) - Q_CW'(pop);
    end
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

/* hdl/ccbd_div.sv */
// ---------------------------------------------------------------------------
// ccbd_div: block average divider and result register
// Divides the three block sums by block squared, one quotient bit a cycle,
// and holds the thumbnail pixel until the receiver takes it.
// ---------------------------------------------------------------------------
module ccbd_div #(
  parameter int SUM_W = 24,
  parameter int DIV_W = 16,
  parameter int ENT_W = 84
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  logic [ENT_W-1:0] q_data,
  output logic             q_pop,
  input  logic [DIV_W-1:0] div,
  ccbd_res_if.source       res
);
  import ccbd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  localparam int PW = $bits(pos_t);

  state_t               state_r;
  logic [SUM_W-1:0]     rem_r [3];
  logic [CH_W-1:0]      quo_r [3];
  logic [DIV_W+QB-2:0]  dsh_r;
  logic [2:0]           cnt_r;
  pos_t                 pos_r;
  logic                 out_v_r;
  logic [CH_W-1:0]      o_r_r, o_g_r, o_b_r;
  pos_t                 o_pos_r;

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  // registered state, divider and output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      // beat taken; a new one loaded in S_WAIT sets it again instead
      if (out_v_r && res.ready && state_r != S_WAIT) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            for (int c = 0; c < 3; c++) begin
              rem_r[c] <= q_data[PW + c*SUM_W +: SUM_W];
            end
            pos_r   <= q_data[PW-1:0];
            dsh_r   <= {div, {(QB-1){1'b0}}};
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          for (int c = 0; c < 3; c++) begin
            if (rem_r[c] >= SUM_W'(dsh_r)) begin
              rem_r[c] <= rem_r[c] - SUM_W'(dsh_r);
              quo_r[c] <= {quo_r[c][CH_W-2:0], 1'b1};
            end else begin
              quo_r[c] <= {quo_r[c][CH_W-2:0], 1'b0};
            end
          end
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 3'(QB - 1)) state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_v_r || res.ready) begin
            out_v_r <= 1'b1;
            o_r_r   <= quo_r[0];
            o_g_r   <= quo_r[1];
            o_b_r   <= quo_r[2];
            o_pos_r <= pos_r;
            state_r <= S_IDLE;
          end else begin
            out_v_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res.valid      = out_v_r;
  assign res.out_red    = o_r_r;
  assign res.out_green  = o_g_r;
  assign res.out_blue   = o_b_r;
  assign res.out_column = o_pos_r.col;
  assign res.out_row    = o_pos_r.row;
  assign res.frame_last = o_pos_r.last;

endmodule

/* hdl/center_crop_box_downscaler.sv */
// ---------------------------------------------------------------------------
// center_crop_box_downscaler: 64x32 thumbnail from a raster RGB stream
// Crops a centred 2:1 window from the source and box-averages it.
// ---------------------------------------------------------------------------
// Channels: in_pix takes one source pixel per beat in raster order; out_res
// gives one thumbnail pixel per beat with its column, row and a frame_last
// flag; cfg_wr writes source_width (index 0) or source_height (index 1); the
// user must write only while idle, which the block does not enforce. A write
// restarts the frame and holds in_pix.ready low for one cycle while the crop
// geometry is recomputed. Throughput: one pixel per cycle while the block
// queue has room. Each block result goes through a shared restoring divider
// that takes one result at a time; along a block's bottom row a result is
// due every "block side" pixels, so when that is shorter than the divider's
// time per result the four-entry queue fills and the pixel input stalls to
// the divider rate.
// Reset: source size 64x32, position at frame start, queue and result empty.
// The column store needs no clearing: a block's top-left pixel starts its sum.
// When the receiver stalls, the result is held, the divider waits, and the
// queue then the pixel input back up.
// ---------------------------------------------------------------------------
module center_crop_box_downscaler #(
  parameter int MAX_SOURCE_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  ccbd_pix_if.sink    in_pix,
  ccbd_res_if.source  out_res,
  ccbd_cfg_if.sink    cfg_wr
);
  import ccbd_pkg::*;

  localparam int DIM_W = $clog2(MAX_SOURCE_DIM + 1);
  localparam int BLK_W = DIM_W - 5;
  localparam int DIV_W = 2 * BLK_W;
  localparam int SUM_W = DIV_W + CH_W;
  localparam int ENT_W = 3 * SUM_W + $bits(pos_t);

  logic             q_push, q_pop, q_empty, q_full, q_afull;
  logic [ENT_W-1:0] q_wdata, q_rdata;
  logic [DIV_W-1:0] div;

  ccbd_front #(
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
    .DIM_W          (DIM_W),
    .BLK_W          (BLK_W),
    .SUM_W          (SUM_W),
    .DIV_W          (DIV_W),
    .ENT_W          (ENT_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_wr),
    .pix     (in_pix),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full),
    .q_afull (q_afull),
    .div     (div)
  );

  ccbd_fifo #(.WIDTH(ENT_W)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full),
    .afull (q_afull)
  );

  ccbd_div #(.SUM_W(SUM_W), .DIV_W(DIV_W), .ENT_W(ENT_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .div     (div),
    .res     (out_res)
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("block queue overflow");

  a_geo_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr.valid && cfg_wr.ready) |=> !in_pix.ready)
    else $error("pixel taken before geometry update");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.frame_last) |->
      (out_res.out_column == LAST_COL && out_res.out_row == LAST_ROW))
    else $error("frame_last on wrong thumbnail pixel");

endmodule
